FILE: hdl/assert_macros.svh
// Assertion macros for the raster-to-block design files.
// Included by each module that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/r2b_pkg.sv
// Package for the raster-to-block reorder: sizes, register indexes and shared types.
// Used by every module of the block; depends on nothing.
package r2b_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ADDR_W     = COL_W + 4;
    localparam int DEPTH      = 16 * MAX_WIDTH;
    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int BLK_CNT_W  = 6;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(8);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(8);

    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        RD_IDLE,
        RD_ISSUE,
        RD_DRAIN
    } t_rd_state;

    typedef struct packed {
        logic             bank;
        logic [2:0]       last_row;
        logic [COL_W-1:0] last_col;
        logic             last_image;
    } t_blk_req;

endpackage

FILE: hdl/raster_to_block_edge_pad.sv
// Top level of the raster-to-8x8-block reorder with edge replication.
// Instantiates r2b_ctrl, r2b_readout and r2b_strip_ram; uses r2b_pkg.
//
// Pixels enter on the s_axis channel in raster order, one per beat. Each is written
// into a two-bank strip store of eight rows of MAX_WIDTH pixels. The beat that
// completes an 8x8 block starts a readout of that block's 64 pixels in row-major
// order on the m_axis channel; tlast marks the 64th pixel of each block and tuser
// marks the last pixel of the image. Columns past the width repeat the last column
// and rows past the height repeat the last row.
// Input beats are taken one per cycle while no block is being read out. A block
// readout blocks the input from the cycle after the completing beat until its 64th
// beat leaves; the store reads go one at a time through the single read port, then
// through the store and output registers. A receiver stall holds the output
// register and pauses the store reads. The cfg channel writes image_width (index 0)
// and image_height (index 1). It is always ready; the user must use it only while
// the block is idle, which the block does not enforce. Reset clears the counters,
// sets both registers to 8 and drops all valids; the store needs no clearing.
module raster_to_block_edge_pad
    import r2b_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] pixel_in
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] pixel_out
    output logic                  m_axis_tlast,
    output logic                  m_axis_tuser    // [0] last_in_image
);

    logic              busy;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic [PIX_W-1:0]  rdata;
    logic              req_valid;
    t_blk_req          req;
    t_cfg_index        cfg_index;

    assign o_cfg_ready = 1'b1;
    assign cfg_index   = t_cfg_index'(i_cfg_index);

    r2b_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix_valid (s_axis_tvalid),
        .i_busy      (busy),
        .o_pix_ready (s_axis_tready),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_req_valid (req_valid),
        .o_req       (req)
    );

    r2b_strip_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (s_axis_tdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    r2b_readout u_readout (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_valid),
        .i_req        (req),
        .o_busy       (busy),
        .o_re         (re),
        .o_raddr      (raddr),
        .i_rdata      (rdata),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_pixel      (m_axis_tdata),
        .o_last_block (m_axis_tlast),
        .o_last_image (m_axis_tuser)
    );

endmodule

FILE: hdl/r2b_strip_ram.sv
// Ping-pong strip store: one write port and one read port with registered read data.
// Read data holds while no read is enabled. Uses r2b_pkg for sizes.
module r2b_strip_ram
    import r2b_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [PIX_W-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [PIX_W-1:0]  o_rdata
);

    logic [PIX_W-1:0] r_mem [0:DEPTH-1];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/r2b_ctrl.sv
// Input side: configuration registers, raster column/row/bank counters and store writes.
// Raises a block request on the pixel that completes a block. Uses r2b_pkg.
module r2b_ctrl
    import r2b_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  t_cfg_index            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_pix_valid,
    input  logic                  i_busy,
    output logic                  o_pix_ready,
    output logic                  o_we,
    output logic [ADDR_W-1:0]     o_waddr,
    output logic                  o_req_valid,
    output t_blk_req              o_req
);

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [COL_W-1:0]    r_col;
    logic [HEIGHT_W-1:0] r_row;
    logic                r_bank;
    logic [COL_W-1:0]    n_col;
    logic [HEIGHT_W-1:0] n_row;
    logic                n_bank;
    logic [WIDTH_W-1:0]  eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic                accept;
    logic                last_col;
    logic                last_row;
    logic                strip_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            eff_w = WIDTH_W'(1);
        end else if (r_width > WIDTH_W'(MAX_WIDTH)) begin
            eff_w = WIDTH_W'(MAX_WIDTH);
        end else begin
            eff_w = r_width;
        end
        eff_h = (r_height == '0) ? HEIGHT_W'(1) : r_height;
    end

    assign o_pix_ready = !i_busy;
    assign accept      = i_pix_valid && !i_busy;
    assign last_col    = WIDTH_W'(r_col) >= (eff_w - WIDTH_W'(1));
    assign last_row    = r_row >= (eff_h - HEIGHT_W'(1));
    assign strip_end   = (r_row[2:0] == 3'd7) || last_row;

    assign o_we    = accept;
    assign o_waddr = {r_bank, r_row[2:0], r_col};

    assign o_req_valid     = accept && strip_end && ((r_col[2:0] == 3'd7) || last_col);
    assign o_req.bank       = r_bank;
    assign o_req.last_row   = r_row[2:0];
    assign o_req.last_col   = r_col;
    assign o_req.last_image = last_row && last_col;

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_bank = r_bank;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                if (strip_end) begin
                    n_bank = !r_bank;
                end
                n_row = last_row ? '0 : r_row + HEIGHT_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_bank <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_bank <= n_bank;
        end
    end

endmodule

FILE: hdl/r2b_readout.sv
// Block readout: walks the 64 positions of an 8x8 block with edge clamping, reads the
// strip store and drives the output register with flags. Uses r2b_pkg and assert_macros.svh.
`include "assert_macros.svh"
module r2b_readout
    import r2b_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  t_blk_req          i_req,
    output logic              o_busy,
    output logic              o_re,
    output logic [ADDR_W-1:0] o_raddr,
    input  logic [PIX_W-1:0]  i_rdata,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [PIX_W-1:0]  o_pixel,
    output logic              o_last_block,
    output logic              o_last_image
);

    t_rd_state            r_state;
    t_rd_state            n_state;
    t_blk_req             r_req;
    logic [BLK_CNT_W-1:0] r_k;
    logic                 r_rd_vld;
    logic                 r_rd_lb;
    logic                 r_rd_li;
    logic                 r_ov;
    logic [PIX_W-1:0]     r_pix;
    logic                 r_lb;
    logic                 r_li;
    logic                 move;
    logic                 k_last;
    logic [2:0]           sy;
    logic [COL_W-1:0]     sx;

    assign move   = r_rd_vld && (!r_ov || i_ready);
    assign k_last = r_k == '1;

    always_comb begin
        sy = (r_k[5:3] < r_req.last_row) ? r_k[5:3] : r_req.last_row;
        sx = {r_req.last_col[COL_W-1:3], r_k[2:0]};
        if (sx > r_req.last_col) begin
            sx = r_req.last_col;
        end
    end

    assign o_raddr = {r_req.bank, sy, sx};

    always_comb begin
        n_state = r_state;
        o_re    = 1'b0;
        case (r_state)
            RD_IDLE: begin
                if (i_req_valid) begin
                    n_state = RD_ISSUE;
                end
            end
            RD_ISSUE: begin
                o_re = !r_rd_vld || move;
                if (o_re && k_last) begin
                    n_state = RD_DRAIN;
                end
            end
            RD_DRAIN: begin
                if (r_ov && i_ready && r_lb) begin
                    n_state = RD_IDLE;
                end
            end
            default: n_state = RD_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= RD_IDLE;
            r_k      <= '0;
            r_rd_vld <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == RD_IDLE && i_req_valid) begin
                r_k <= '0;
            end else if (o_re) begin
                r_k <= r_k + BLK_CNT_W'(1);
            end
            if (o_re) begin
                r_rd_vld <= 1'b1;
            end else if (move) begin
                r_rd_vld <= 1'b0;
            end
            if (move) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == RD_IDLE && i_req_valid) begin
            r_req <= i_req;
        end
        if (o_re) begin
            r_rd_lb <= k_last;
            r_rd_li <= k_last && r_req.last_image;
        end
        if (move) begin
            r_pix <= i_rdata;
            r_lb  <= r_rd_lb;
            r_li  <= r_rd_li;
        end
    end

    assign o_busy       = r_state != RD_IDLE;
    assign o_valid      = r_ov;
    assign o_pixel      = r_pix;
    assign o_last_block = r_lb;
    assign o_last_image = r_li;

    `ASSERT_ALWAYS(a_no_read_idle, i_clk, i_rst_n, !(r_state == RD_IDLE && o_re))
    `ASSERT_ALWAYS(a_req_when_idle, i_clk, i_rst_n, !(i_req_valid && r_state != RD_IDLE))
    `ASSERT_ALWAYS(a_out_only_busy, i_clk, i_rst_n, !(r_ov && r_state == RD_IDLE))
    `ASSERT_NEXT(a_last_read_drain, i_clk, i_rst_n, o_re && k_last, r_state == RD_DRAIN)

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for raster_to_block_edge_pad: raster pixels go in, 8x8 blocks come out.
// A predictor keeps its own strip store copy and compares every output beat; uses r2b_pkg.
module tb_top;
    import r2b_pkg::*;

    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 300;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             blk_end;
        logic             img_end;
    } t_block_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic                  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    logic [PIX_W-1:0]    strip_copy [0:16*MAX_WIDTH-1];
    int unsigned         fill_col;
    int unsigned         fill_row;
    logic                fill_bank;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    t_block_beat         block_beats_q[$];
    int                  mismatches;
    bit                  idle_on;
    int                  stall_left;

    raster_to_block_edge_pad dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned eff_width(input logic [WIDTH_W-1:0] raw);
        if (raw == '0) return 1;
        if (raw > MAX_WIDTH) return MAX_WIDTH;
        return raw;
    endfunction

    function automatic void reorder_pixel(input logic [PIX_W-1:0] pix);
        int unsigned w, h, col, row, rows_up, base, sx, sy, bank_base, y, x;
        bit          last_col, last_row, strip_done;
        t_block_beat beat;
        w = eff_width(width_reg);
        h = (height_reg == '0) ? 1 : height_reg;
        col = (fill_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : fill_col;
        row = fill_row;
        bank_base = fill_bank ? 8 * MAX_WIDTH : 0;
        strip_copy[bank_base + (row % 8) * MAX_WIDTH + col] = pix;
        last_col = (col >= w - 1);
        last_row = (row >= h - 1);
        strip_done = (row % 8 == 7) || last_row;
        if (strip_done && ((col % 8 == 7) || last_col)) begin
            base = col - col % 8;
            rows_up = row % 8;
            for (y = 0; y < 8; y++) begin
                for (x = 0; x < 8; x++) begin
                    sy = (y < rows_up) ? y : rows_up;
                    sx = (base + x > col) ? col : base + x;
                    beat.pixel = strip_copy[bank_base + sy * MAX_WIDTH + sx];
                    beat.blk_end = (y == 7) && (x == 7);
                    beat.img_end = beat.blk_end && last_row && last_col;
                    block_beats_q.push_back(beat);
                end
            end
        end
        if (last_col) begin
            fill_col = 0;
            if (strip_done) fill_bank = ~fill_bank;
            fill_row = last_row ? 0 : (row + 1) % 65536;
        end else begin
            fill_col = col + 1;
        end
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        do @(posedge i_clk); while (!s_axis_tready);
        reorder_pixel(pix);
        @(negedge i_clk);
    endtask

    task automatic send_run(input int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) send_pixel(8'h00);
            else if (pick == 1) send_pixel(8'hFF);
            else send_pixel(PIX_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic quiesce;
        s_axis_tvalid <= 1'b0;
        while (block_beats_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_IMAGE_WIDTH) width_reg = value[WIDTH_W-1:0];
        else height_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic test_default_size;
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_run(62);
        quiesce;
    endtask

    task automatic test_edge_replication;
        write_reg(CFG_IMAGE_WIDTH, 16'd5);
        write_reg(CFG_IMAGE_HEIGHT, 16'd3);
        send_run(15);
        quiesce;
    endtask

    task automatic test_degenerate_sizes;
        write_reg(CFG_IMAGE_WIDTH, 16'd0);
        write_reg(CFG_IMAGE_HEIGHT, 16'd0);
        send_run(2);
        quiesce;
        write_reg(CFG_IMAGE_WIDTH, 16'd1);
        write_reg(CFG_IMAGE_HEIGHT, 16'd2);
        send_run(2);
        quiesce;
    endtask

    task automatic test_widest_rows;
        // The all-ones write sets the width above MAX_WIDTH, so rows are clamped to MAX_WIDTH.
        write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(CFG_IMAGE_HEIGHT, 16'd1);
        send_run(24);
        quiesce;
        // Narrowing the width below the current column ends the row at the next pixel.
        write_reg(CFG_IMAGE_WIDTH, 16'd24);
        send_run(1);
        quiesce;
    endtask

    task automatic test_height_cut_mid_image;
        write_reg(CFG_IMAGE_WIDTH, 16'd3);
        write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
        send_run(30);
        quiesce;
        write_reg(CFG_IMAGE_HEIGHT, 16'd2);
        send_run(3);
        quiesce;
    endtask

    task automatic test_width_cut_mid_row;
        write_reg(CFG_IMAGE_WIDTH, 16'd16);
        write_reg(CFG_IMAGE_HEIGHT, 16'd8);
        send_run(2 * 16 + 11);
        quiesce;
        write_reg(CFG_IMAGE_WIDTH, 16'd4);
        send_run(1 + 5 * 4);
        quiesce;
    endtask

    // The width may only grow at the start of a strip, so that every block
    // reads store entries written in the same strip.
    task automatic test_random_images;
        int unsigned           raw;
        logic [CFG_DATA_W-1:0] value;
        int                    run_len;
        int                    random_sent;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            idle_on = (random_sent < RANDOM_ITEMS - 100) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0) begin
                quiesce;
                if ($urandom_range(0, 2) != 0) begin
                    if (fill_col == 0 && fill_row % 8 == 0) begin
                        case ($urandom_range(0, 7))
                            0: raw = 0;
                            1: raw = $urandom_range(25, 80);
                            default: raw = $urandom_range(1, 24);
                        endcase
                    end else begin
                        raw = $urandom_range(1, eff_width(width_reg));
                    end
                    value = CFG_DATA_W'(raw);
                    if ($urandom_range(0, 3) == 0)
                        value = value | (CFG_DATA_W'($urandom_range(1, 31)) << WIDTH_W);
                    write_reg(CFG_IMAGE_WIDTH, value);
                end
                if ($urandom_range(0, 2) != 0) begin
                    case ($urandom_range(0, 7))
                        0: raw = 0;
                        1: raw = $urandom_range(21, 40);
                        default: raw = $urandom_range(1, 20);
                    endcase
                    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(raw));
                end
            end
            run_len = $urandom_range(1, 120);
            send_run(run_len);
            random_sent += run_len;
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_block_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (block_beats_q.size() == 0) begin
                $error("output beat with no block pending");
                mismatches++;
            end else begin
                want = block_beats_q.pop_front();
                if (m_axis_tdata !== want.pixel) begin
                    $error("pixel_out expected %0d, got %0d", want.pixel, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== want.blk_end) begin
                    $error("last_in_block expected %0d, got %0d", want.blk_end, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser !== want.img_end) begin
                    $error("last_in_image expected %0d, got %0d", want.img_end, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #6_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_IMAGE_WIDTH;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        idle_on = 1'b1;
        stall_left = 0;
        mismatches = 0;
        width_reg = WIDTH_RST;
        height_reg = HEIGHT_RST;
        fill_col = 0;
        fill_row = 0;
        fill_bank = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_size;
        test_edge_replication;
        test_degenerate_sizes;
        test_widest_rows;
        test_height_cut_mid_image;
        test_width_cut_mid_row;
        test_random_images;
        quiesce;

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
